// ===== rtl/core/tffa_pkg.sv =====
// Package for the timed first-fit allocator: payload structs, status codes,
// sequencer states and the control structs that drive the segment cells.
// Used by every module under rtl/core.
package tffa_pkg;

    localparam int          MAX_SEGMENTS_DEF = 16;
    localparam int          TIME_BITS_DEF    = 20;
    localparam logic [15:0] TOTAL_RESET      = 16'd256;

    typedef enum logic [1:0] {
        ST_PLACED     = 2'd0,
        ST_TOO_LARGE  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [19:0] arrival_time;
        logic [19:0] duration;
        logic [15:0] request_size;
        logic [7:0]  owner_id;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] start_address;
        logic [19:0] start_time;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_FLUSH,
        S_DECIDE,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_QUEUE,
        CELL_PLACE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     pop;
        logic     push;
        logic     split;
    } cell_ctl_t;

    typedef struct packed {
        logic clear;
        logic pop;
        logic flush;
    } scan_ctl_t;

endpackage

// ===== rtl/core/tffa_cell.sv =====
// One segment cell of the allocator chain: size, end tick and held flag.
// Depends on tffa_pkg for the cell control struct.
module tffa_cell #(
    parameter int INDEX        = 0,
    parameter int MAX_SEGMENTS = tffa_pkg::MAX_SEGMENTS_DEF,
    parameter int TIME_BITS    = tffa_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tffa_pkg::cell_ctl_t                 ctl,
    input  logic [15:0]                         init_size,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]   wpos,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]   fidx,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]   fidx_nxt,
    input  logic [15:0]                         wr_size,
    input  logic [TIME_BITS-1:0]                wr_end,
    input  logic                                wr_held,
    input  logic [15:0]                         rem_size,
    input  logic [15:0]                         up_size,
    input  logic [TIME_BITS-1:0]                up_end,
    input  logic                                up_held,
    input  logic [15:0]                         dn_size,
    input  logic [TIME_BITS-1:0]                dn_end,
    input  logic                                dn_held,
    output logic [15:0]                         size,
    output logic [TIME_BITS-1:0]                end_tick,
    output logic                                held
);
    import tffa_pkg::*;

    localparam int             CW    = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0]  MY    = CW'(INDEX);
    localparam bit             FIRST = (INDEX == 0);

    logic [15:0]          size_reg, size_next;
    logic [TIME_BITS-1:0] end_reg, end_next;
    logic                 held_reg, held_next;

    always_comb
    begin
        size_next = size_reg;
        end_next  = end_reg;
        held_next = held_reg;
        case (ctl.op)
            CELL_INIT:
            begin
                size_next = FIRST ? init_size : '0;
                end_next  = '0;
                held_next = 1'b0;
            end
            CELL_QUEUE:
            begin
                // advance toward the head, then take the tail write
                if (ctl.pop)
                begin
                    size_next = up_size;
                    end_next  = up_end;
                    held_next = up_held;
                end
                if (ctl.push && MY == wpos)
                begin
                    size_next = wr_size;
                    end_next  = wr_end;
                    held_next = wr_held;
                end
            end
            CELL_PLACE:
            begin
                if (MY == fidx)
                begin
                    size_next = wr_size;
                    end_next  = wr_end;
                    held_next = wr_held;
                end
                else if (ctl.split && MY == fidx_nxt)
                begin
                    size_next = rem_size;
                    end_next  = '0;
                    held_next = 1'b0;
                end
                else if (ctl.split && MY > fidx_nxt)
                begin
                    size_next = dn_size;
                    end_next  = dn_end;
                    held_next = dn_held;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= FIRST ? TOTAL_RESET : '0;
            end_reg  <= '0;
            held_reg <= 1'b0;
        end
        else
        begin
            size_reg <= size_next;
            end_reg  <= end_next;
            held_reg <= held_next;
        end
    end

    assign size     = size_reg;
    assign end_tick = end_reg;
    assign held     = held_reg;

endmodule

// ===== rtl/core/tffa_scan.sv =====
// Head unit of the allocator chain: expires and merges the popped stream,
// emits the compacted table and tracks the first fit and next end tick.
// Depends on tffa_pkg for the scan control struct.
module tffa_scan #(
    parameter int MAX_SEGMENTS = tffa_pkg::MAX_SEGMENTS_DEF,
    parameter int TIME_BITS    = tffa_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tffa_pkg::scan_ctl_t                 ctl,
    input  logic [TIME_BITS-1:0]                tick,
    input  logic [15:0]                         req_size,
    input  logic [15:0]                         head_size,
    input  logic [TIME_BITS-1:0]                head_end,
    input  logic                                head_held,
    output logic                                emit_valid,
    output logic [15:0]                         emit_size,
    output logic [TIME_BITS-1:0]                emit_end,
    output logic                                emit_held,
    output logic                                found,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0]   fidx,
    output logic [15:0]                         faddr,
    output logic [15:0]                         fsize,
    output logic                                any_held,
    output logic [TIME_BITS-1:0]                next_tick
);
    import tffa_pkg::*;

    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic                 acc_v_reg, acc_v_next;
    logic [15:0]          acc_size_reg, acc_size_next;
    logic [TIME_BITS-1:0] acc_end_reg, acc_end_next;
    logic                 acc_held_reg, acc_held_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        fidx_reg, fidx_next;
    logic [CW-1:0]        eidx_reg, eidx_next;
    logic [15:0]          addr_reg, addr_next;
    logic [15:0]          fsize_reg, fsize_next;
    logic                 any_reg, any_next;
    logic [TIME_BITS-1:0] nt_reg, nt_next;
    logic                 h_held;

    // a segment stays held only while the tick is before its end
    assign h_held = head_held && (tick < head_end);

    always_comb
    begin
        acc_v_next    = acc_v_reg;
        acc_size_next = acc_size_reg;
        acc_end_next  = acc_end_reg;
        acc_held_next = acc_held_reg;
        emit_valid    = 1'b0;
        if (ctl.pop)
        begin
            if (acc_v_reg && !acc_held_reg && !h_held)
            begin
                acc_size_next = acc_size_reg + head_size;
            end
            else
            begin
                emit_valid    = acc_v_reg;
                acc_v_next    = 1'b1;
                acc_size_next = head_size;
                acc_end_next  = head_end;
                acc_held_next = h_held;
            end
        end
        else if (ctl.flush)
        begin
            emit_valid = acc_v_reg;
            acc_v_next = 1'b0;
        end
        if (ctl.clear)
        begin
            acc_v_next = 1'b0;
        end
    end

    assign emit_size = acc_size_reg;
    assign emit_end  = acc_end_reg;
    assign emit_held = acc_held_reg;

    always_comb
    begin
        found_next = found_reg;
        fidx_next  = fidx_reg;
        eidx_next  = eidx_reg;
        addr_next  = addr_reg;
        fsize_next = fsize_reg;
        any_next   = any_reg;
        nt_next    = nt_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
            eidx_next  = '0;
            addr_next  = '0;
            any_next   = 1'b0;
            nt_next    = '0;
        end
        else if (emit_valid)
        begin
            eidx_next = eidx_reg + 1'b1;
            if (!found_reg)
            begin
                if (!acc_held_reg && acc_size_reg >= req_size)
                begin
                    found_next = 1'b1;
                    fidx_next  = eidx_reg;
                    fsize_next = acc_size_reg;
                end
                else
                begin
                    addr_next = addr_reg + acc_size_reg;
                end
            end
            if (acc_held_reg)
            begin
                any_next = 1'b1;
                if (!any_reg || acc_end_reg < nt_reg)
                begin
                    nt_next = acc_end_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_v_reg <= 1'b0;
            found_reg <= 1'b0;
            eidx_reg  <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            acc_v_reg <= acc_v_next;
            found_reg <= found_next;
            eidx_reg  <= eidx_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_size_reg <= acc_size_next;
        acc_end_reg  <= acc_end_next;
        acc_held_reg <= acc_held_next;
        fidx_reg     <= fidx_next;
        addr_reg     <= addr_next;
        fsize_reg    <= fsize_next;
        nt_reg       <= nt_next;
    end

    assign found     = found_reg;
    assign fidx      = fidx_reg;
    assign faddr     = addr_reg;
    assign fsize     = fsize_reg;
    assign any_held  = any_reg;
    assign next_tick = nt_reg;

endmodule

// ===== rtl/core/timed_first_fit_allocator.sv =====
// Top level of the timed first-fit allocator: sequencer, segment chain and
// head unit. Depends on tffa_pkg, tffa_cell and tffa_scan.
//
// Usage:
//   Requests enter on req (valid/stall); one result per request leaves on
//   rsp (valid/stall). cfg_we with cfg_data writes total_size and reloads
//   the table to one free segment of that size; write it only while idle.
//   The table sits in a chain of MAX_SEGMENTS cells used as a shift queue.
//   Each pass pops every live segment into the head unit, which expires,
//   merges and emits the compacted table back into the tail while it finds
//   the first fit and the earliest end tick still held.
//   A request larger than total_size is rejected without a pass. Otherwise
//   each tick tried pops every live segment, then flushes the head unit
//   and decides, and the result is then handed off; a request that has to
//   wait for expiry ticks repeats that pass for each tick it tries. The pass
//   through the chain moves one segment out of the head per cycle.
//   One request is in flight at a time; req_stall is low only while idle
//   and no cfg_we is present, and a new request may enter while the
//   previous result still waits.
//   Reset loads total_size 256 and one free segment. A stalled receiver
//   holds rsp; the block finishes the next request and then waits for it.
module timed_first_fit_allocator #(
    parameter int MAX_SEGMENTS = tffa_pkg::MAX_SEGMENTS_DEF,
    parameter int TIME_BITS    = tffa_pkg::TIME_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tffa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tffa_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_data
);
    import tffa_pkg::*;

    localparam int                   CW   = $clog2(MAX_SEGMENTS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam logic [CW-1:0]        NSEG = CW'(MAX_SEGMENTS);

    state_t               state_reg, state_next;
    logic [15:0]          total_reg, total_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [19:0]          dur_reg, dur_next;
    logic [15:0]          rq_reg, rq_next;
    logic                 own_reg, own_next;
    logic [CW-1:0]        occ_reg, occ_next;
    logic [CW-1:0]        pops_reg, pops_next;
    rsp_t                 pend_reg, pend_next;
    logic                 out_v_reg, out_v_next;
    rsp_t                 out_reg, out_next;

    cell_ctl_t            cctl;
    scan_ctl_t            sctl;
    logic [CW-1:0]        wpos;
    logic [15:0]          wr_size;
    logic [TIME_BITS-1:0] wr_end;
    logic                 wr_held;

    logic                 emit_valid;
    logic [15:0]          emit_size;
    logic [TIME_BITS-1:0] emit_end;
    logic                 emit_held;
    logic                 found;
    logic [CW-1:0]        fidx;
    logic [15:0]          faddr;
    logic [15:0]          fsize;
    logic                 any_held;
    logic [TIME_BITS-1:0] next_tick;

    logic [15:0]          c_size [MAX_SEGMENTS];
    logic [TIME_BITS-1:0] c_end  [MAX_SEGMENTS];
    logic                 c_held [MAX_SEGMENTS];

    logic [31:0]          arr32;
    logic [32:0]          sum33;
    logic [TIME_BITS-1:0] place_end;
    logic [31:0]          t32;
    logic                 split;
    logic                 accept;

    assign accept = req_valid && !req_stall;
    assign arr32  = 32'(req.arrival_time);
    assign t32    = 32'(t_reg);
    // end tick of the placement, saturating at the top of the time range
    assign sum33     = 33'(t_reg) + 33'(dur_reg);
    assign place_end = (sum33 > 33'(TMAX)) ? TMAX : sum33[TIME_BITS-1:0];
    assign split     = fsize > rq_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        t_next     = t_reg;
        dur_next   = dur_reg;
        rq_next    = rq_reg;
        own_next   = own_reg;
        occ_next   = occ_reg;
        pops_next  = pops_reg;
        pend_next  = pend_reg;
        out_v_next = out_v_reg;
        out_next   = out_reg;
        cctl       = '{op: CELL_HOLD, pop: 1'b0, push: 1'b0, split: 1'b0};
        sctl       = '{clear: 1'b0, pop: 1'b0, flush: 1'b0};
        wpos       = occ_reg;
        wr_size    = emit_size;
        wr_end     = emit_end;
        wr_held    = emit_held;

        // drop the result once the receiver takes it
        if (out_v_reg && !rsp_stall)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    total_next = cfg_data;
                    occ_next   = CW'(1);
                    cctl.op    = CELL_INIT;
                end
                else if (accept)
                begin
                    dur_next  = req.duration;
                    rq_next   = req.request_size;
                    own_next  = req.owner_id != 8'd0;
                    t_next    = (arr32 > 32'(TMAX)) ? TMAX : arr32[TIME_BITS-1:0];
                    pend_next = '{status: ST_TOO_LARGE, start_address: 16'd0,
                                  start_time: 20'd0};
                    if (req.request_size > total_reg)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        sctl.clear = 1'b1;
                        pops_next  = occ_reg;
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                // pop the head into the scan unit, push its emission at the tail
                sctl.pop  = 1'b1;
                cctl.op   = CELL_QUEUE;
                cctl.pop  = 1'b1;
                cctl.push = emit_valid;
                wpos      = occ_reg - 1'b1;
                occ_next  = occ_reg - 1'b1 + CW'(emit_valid);
                pops_next = pops_reg - 1'b1;
                if (pops_reg == CW'(1))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                sctl.flush = 1'b1;
                cctl.op    = CELL_QUEUE;
                cctl.push  = emit_valid;
                occ_next   = occ_reg + CW'(emit_valid);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (found)
                begin
                    if (split && occ_reg >= NSEG)
                    begin
                        pend_next  = '{status: ST_TABLE_FULL, start_address: 16'd0,
                                       start_time: 20'd0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cctl.op    = CELL_PLACE;
                        cctl.split = split;
                        wr_size    = rq_reg;
                        wr_end     = place_end;
                        wr_held    = own_reg;
                        if (split)
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                        pend_next  = '{status: ST_PLACED, start_address: faddr,
                                       start_time: t32[19:0]};
                        state_next = S_RESP;
                    end
                end
                else if (!any_held)
                begin
                    pend_next  = '{status: ST_TABLE_FULL, start_address: 16'd0,
                                   start_time: 20'd0};
                    state_next = S_RESP;
                end
                else
                begin
                    // advance to the earliest end tick still held and retry
                    if (next_tick > t_reg)
                    begin
                        t_next = next_tick;
                    end
                    else if (t_reg < TMAX)
                    begin
                        t_next = t_reg + 1'b1;
                    end
                    sctl.clear = 1'b1;
                    pops_next  = occ_reg;
                    state_next = S_PASS;
                end
            end
            S_RESP:
            begin
                if (!out_v_reg || !rsp_stall)
                begin
                    out_v_next = 1'b1;
                    out_next   = pend_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= TOTAL_RESET;
            occ_reg   <= CW'(1);
            pops_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            occ_reg   <= occ_next;
            pops_reg  <= pops_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        dur_reg  <= dur_next;
        rq_reg   <= rq_next;
        own_reg  <= own_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // hold requests off while a total_size write is present
    assign req_stall = (state_reg != S_IDLE) || cfg_we;
    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    // ---------------------------------------------------------------
    // segment chain
    // ---------------------------------------------------------------
    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        logic [15:0]          up_size, dn_size;
        logic [TIME_BITS-1:0] up_end, dn_end;
        logic                 up_held, dn_held;

        if (g == MAX_SEGMENTS - 1)
        begin : g_top
            assign up_size = '0;
            assign up_end  = '0;
            assign up_held = 1'b0;
        end
        else
        begin : g_mid
            assign up_size = c_size[g+1];
            assign up_end  = c_end[g+1];
            assign up_held = c_held[g+1];
        end

        if (g == 0)
        begin : g_bot
            assign dn_size = '0;
            assign dn_end  = '0;
            assign dn_held = 1'b0;
        end
        else
        begin : g_low
            assign dn_size = c_size[g-1];
            assign dn_end  = c_end[g-1];
            assign dn_held = c_held[g-1];
        end

        tffa_cell #(
            .INDEX        (g),
            .MAX_SEGMENTS (MAX_SEGMENTS),
            .TIME_BITS    (TIME_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cctl),
            .init_size (cfg_data),
            .wpos      (wpos),
            .fidx      (fidx),
            .fidx_nxt  (fidx + 1'b1),
            .wr_size   (wr_size),
            .wr_end    (wr_end),
            .wr_held   (wr_held),
            .rem_size  (fsize - rq_reg),
            .up_size   (up_size),
            .up_end    (up_end),
            .up_held   (up_held),
            .dn_size   (dn_size),
            .dn_end    (dn_end),
            .dn_held   (dn_held),
            .size      (c_size[g]),
            .end_tick  (c_end[g]),
            .held      (c_held[g])
        );
    end

    tffa_scan #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .TIME_BITS    (TIME_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .tick       (t_reg),
        .req_size   (rq_reg),
        .head_size  (c_size[0]),
        .head_end   (c_end[0]),
        .head_held  (c_held[0]),
        .emit_valid (emit_valid),
        .emit_size  (emit_size),
        .emit_end   (emit_end),
        .emit_held  (emit_held),
        .found      (found),
        .fidx       (fidx),
        .faddr      (faddr),
        .fsize      (fsize),
        .any_held   (any_held),
        .next_tick  (next_tick)
    );

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= NSEG)
        else $error("segment count above table size");

    a_occ_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> occ_reg != '0)
        else $error("segment table empty while idle");

    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        cctl.op == CELL_PLACE && cctl.split |-> occ_reg < NSEG)
        else $error("split into a full table");

    a_flush_after_pops: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> pops_reg == '0)
        else $error("flush before all segments popped");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && (!out_v_reg || !rsp_stall) |=> rsp_valid)
        else $error("finished result not presented");

endmodule

// ===== tb/sv/tb_timed_first_fit_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking bench for timed_first_fit_allocator: directed and random requests
// against a segment-table predictor. Depends on tffa_pkg and the allocator RTL.

import tffa_pkg::*;

// Mirror of the segment table; predicts one response per accepted request
class alloc_scoreboard;
    localparam int SEGS = 16;
    localparam longint unsigned TICK_MAX = 64'hFFFFF;

    int unsigned     mem_size;
    int unsigned     size_q[SEGS];
    longint unsigned begin_q[SEGS];
    longint unsigned len_q[SEGS];
    int unsigned     owner_q[SEGS];
    int              live;
    rsp_t            pending_rsp[$];
    int              mismatches;

    function void load_size(int unsigned v);
        mem_size = v;
        for (int i = 0; i < SEGS; i++)
        begin
            size_q[i] = 0;
            begin_q[i] = 0;
            len_q[i] = 0;
            owner_q[i] = 0;
        end
        size_q[0] = v;
        live = 1;
    endfunction

    function longint unsigned end_tick(int i);
        longint unsigned e;
        e = begin_q[i] + len_q[i];
        return (e > TICK_MAX) ? TICK_MAX : e;
    endfunction

    // Free everything ended by tick t, then coalesce runs of free segments
    function void expire_merge(longint unsigned t);
        int j;
        j = 0;
        for (int i = 0; i < live; i++)
            if (t >= end_tick(i))
            begin
                owner_q[i] = 0;
                begin_q[i] = 0;
                len_q[i] = 0;
            end
        for (int i = 0; i < live; i++)
        begin
            if (j > 0 && owner_q[i] == 0 && owner_q[j-1] == 0)
                size_q[j-1] += size_q[i];
            else
            begin
                size_q[j] = size_q[i];
                begin_q[j] = begin_q[i];
                len_q[j] = len_q[i];
                owner_q[j] = owner_q[i];
                j++;
            end
        end
        for (int i = j; i < SEGS; i++)
        begin
            size_q[i] = 0;
            begin_q[i] = 0;
            len_q[i] = 0;
            owner_q[i] = 0;
        end
        live = j;
    endfunction

    function void note_request(req_t r);
        longint unsigned t, next_t;
        int unsigned     need, addr;
        int              i;
        bit              held;
        rsp_t            o;
        t = r.arrival_time;
        need = r.request_size;
        o = '0;
        o.status = ST_TABLE_FULL;
        if (need > mem_size)
        begin
            o.status = ST_TOO_LARGE;
            pending_rsp.push_back(o);
            return;
        end
        for (int iter = 0; iter <= SEGS + 1; iter++)
        begin
            expire_merge(t);
            addr = 0;
            for (i = 0; i < live; i++)
            begin
                if (owner_q[i] == 0 && size_q[i] >= need)
                    break;
                addr += size_q[i];
            end
            if (i < live)
            begin
                if (size_q[i] > need)
                begin
                    if (live >= SEGS)
                    begin
                        pending_rsp.push_back(o);
                        return;
                    end
                    for (int k = live; k > i + 1; k--)
                    begin
                        size_q[k] = size_q[k-1];
                        begin_q[k] = begin_q[k-1];
                        len_q[k] = len_q[k-1];
                        owner_q[k] = owner_q[k-1];
                    end
                    size_q[i+1] = size_q[i] - need;
                    begin_q[i+1] = 0;
                    len_q[i+1] = 0;
                    owner_q[i+1] = 0;
                    live++;
                end
                size_q[i] = need;
                begin_q[i] = t;
                len_q[i] = r.duration;
                owner_q[i] = r.owner_id;
                o.status = ST_PLACED;
                o.start_address = addr[15:0];
                o.start_time = t[19:0];
                pending_rsp.push_back(o);
                return;
            end
            held = 0;
            next_t = 0;
            for (i = 0; i < live; i++)
                if (owner_q[i] != 0)
                begin
                    if (!held || end_tick(i) < next_t)
                        next_t = end_tick(i);
                    held = 1;
                end
            if (!held)
                break;
            t = (next_t > t) ? next_t : ((t < TICK_MAX) ? t + 1 : TICK_MAX);
        end
        pending_rsp.push_back(o);
    endfunction

    function void report(string what, rsp_t exp_r, rsp_t act_r);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected st=%0d addr=%0d t=%0d, got st=%0d addr=%0d t=%0d",
                     what, exp_r.status, exp_r.start_address, exp_r.start_time,
                     act_r.status, act_r.start_address, act_r.start_time);
    endfunction

    function void check_response(rsp_t act_r);
        rsp_t exp_r;
        if (pending_rsp.size() == 0)
        begin
            report("unexpected", '0, act_r);
            return;
        end
        exp_r = pending_rsp.pop_front();
        if (exp_r.status != act_r.status)
            report("status", exp_r, act_r);
        else if (exp_r.start_address != act_r.start_address)
            report("start_address", exp_r, act_r);
        else if (exp_r.start_time != act_r.start_time)
            report("start_time", exp_r, act_r);
    endfunction
endclass

module tb_timed_first_fit_allocator;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;

    // Idle percentages for the sender and the receiver, set per phase
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cur_size = 256;
    int unsigned tick_cursor = 0;

    alloc_scoreboard board;

    timed_first_fit_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver: check every response transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Send one request: random idle cycles first, then hold it until the transfer.
    // Valid is only lowered inside the gap, so it never toggles within one step.
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(r);
    endtask

    // Drain the response queue, let the block settle, then reload total_size
    task automatic write_size(int unsigned v);
        req_valid <= 1'b0;
        while (board.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        board.load_size(v);
        cur_size = v;
        tick_cursor = 0;
    endtask

    function automatic req_t make_request();
        req_t        r;
        int unsigned pick;
        int unsigned cap;
        pick = $urandom_range(99);
        cap = (cur_size / 4 > 0) ? cur_size / 4 : 1;
        if (pick < 8)
        begin
            // noise: any legal field values
            r.arrival_time = 20'($urandom);
            r.duration = 20'($urandom);
            r.request_size = 16'($urandom_range(65535, 1));
            r.owner_id = 8'($urandom_range(255, 1));
            return r;
        end
        // well-formed: time moves forward slowly so segments keep expiring
        tick_cursor = (tick_cursor + $urandom_range(20)) & 20'hFFFFF;
        r.arrival_time = 20'(tick_cursor);
        if (pick < 10)
            r.arrival_time = 20'hFFFFF - 20'($urandom_range(3));
        r.duration = (pick < 14) ? 20'($urandom) : 20'($urandom_range(60));
        r.owner_id = 8'($urandom_range(255, 1));
        if (pick < 18 && cur_size < 65535)
            r.request_size = 16'(cur_size + 1);
        else if (pick < 24)
            r.request_size = 16'(cur_size);
        else
            r.request_size = 16'($urandom_range(cap, 1));
        return r;
    endfunction

    initial
    begin
        req_t r;
        int unsigned sizes[6] = '{256, 65535, 1, 40, 1000, 256};

        board = new;
        board.load_size(256);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the table with fifteen held units, then overflow it
        for (int i = 0; i < 15; i++)
        begin
            r = '{arrival_time: 20'd0, duration: 20'd1000, request_size: 16'd1,
                  owner_id: 8'(i + 1)};
            send_request(r);
        end
        send_request('{20'd0, 20'd1000, 16'd1, 8'd77});        // table full
        send_request('{20'd10, 20'd5, 16'd257, 8'd3});         // larger than memory
        send_request('{20'd2000, 20'd5, 16'd256, 8'd255});     // exact fit
        send_request('{20'd2000, 20'd0, 16'd0, 8'd1});         // zero size, must wait
        send_request('{20'd3000, 20'd50, 16'd10, 8'd0});       // owner zero stays free
        send_request('{20'd3001, 20'd9, 16'd20, 8'd9});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'd100, 8'd200}); // saturated end tick
        send_request('{20'd0, 20'hFFFFF, 16'd200, 8'd128});    // waits to the last tick
        send_request('{20'hFFFFF, 20'd0, 16'hFFFF, 8'hFF});

        // Random phases, each under its own total_size and idle pattern
        for (int p = 0; p < 6; p++)
        begin
            write_size(sizes[p]);
            case (p % 3)
                0: begin send_idle_pct = 28; recv_stall_pct = 59; end
                1: begin send_idle_pct = 59; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 315; n++)
                send_request(make_request());
        end
        req_valid <= 1'b0;

        while (board.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (board.mismatches == 0 && board.pending_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #60ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tffa_pkg.sv
rtl/core/tffa_cell.sv
rtl/core/tffa_scan.sv
rtl/core/timed_first_fit_allocator.sv
tb/sv/tb_timed_first_fit_allocator.sv
